// ----- design/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types and the sextet to ASCII mapping of the base64 encoder.
// ----------------------------------------------------------------------------
package b64_pkg;

   localparam int SEXTET_W = 6;
   localparam int CHAR_W   = 7;

   // one classified input byte: one or two sextets ready for output
   typedef struct packed {
      logic [SEXTET_W-1:0] sx0;
      logic [SEXTET_W-1:0] sx1;
      logic                two;    // sx1 is emitted too
      logic                last;   // final char of this entry ends the message
   } b64_entry_type;

   // front to queue
   typedef struct packed {
      logic          push;
      b64_entry_type entry;
   } b64_push_type;

   // queue to back
   typedef struct packed {
      logic          valid;
      b64_entry_type entry;
   } b64_head_type;

   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] ASCII_DIGIT_0 = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_PLUS    = 7'h2B;
   localparam logic [CHAR_W-1:0] ASCII_SLASH   = 7'h2F;

   function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [SEXTET_W-1:0] sx);
      logic [CHAR_W-1:0] v;
      v = {1'b0, sx};
      if (sx < 6'd26)
         return ASCII_UPPER_A + v;
      else if (sx < 6'd52)
         return ASCII_LOWER_A + v - 7'd26;
      else if (sx < 6'd62)
         return ASCII_DIGIT_0 + v - 7'd52;
      else if (sx == 6'd62)
         return ASCII_PLUS;
      else
         return ASCII_SLASH;
   endfunction

endpackage

// ----- design/b64_stream_if.sv -----
// ----------------------------------------------------------------------------
// b64 stream interfaces
// Valid/ready channels for raw bytes in and base64 characters out.
// ----------------------------------------------------------------------------
interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       end_of_text;

   modport source (output valid, output out_char, output end_of_text, input ready);
   modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

// ----- design/b64_front.sv -----
// ----------------------------------------------------------------------------
// b64_front
// Tracks the position in the 3-byte group and splits each byte into sextets.
// ----------------------------------------------------------------------------
module b64_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   input  logic                  in_final,
   input  logic                  queue_full,
   output b64_pkg::b64_push_type push_out
);
   import b64_pkg::*;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [3:0]    left_ff, left_in;
   b64_entry_type entry;
   logic          take;

   assign in_ready = !queue_full;
   assign take     = in_valid && !queue_full;

   always_comb begin
      entry      = '0;
      entry.last = in_final;
      phase_in   = phase_ff;
      left_in    = left_ff;
      unique case (phase_ff)
         PH_SECOND: begin
            entry.sx0 = {left_ff[1:0], in_byte[7:4]};
            entry.sx1 = {in_byte[3:0], 2'b00};
            entry.two = in_final;
            phase_in  = PH_THIRD;
            left_in   = in_byte[3:0];
         end
         PH_THIRD: begin
            entry.sx0 = {left_ff, in_byte[7:6]};
            entry.sx1 = in_byte[5:0];
            entry.two = 1'b1;
            phase_in  = PH_FIRST;
            left_in   = '0;
         end
         default: begin
            entry.sx0 = in_byte[7:2];
            entry.sx1 = {in_byte[1:0], 4'b0000};
            entry.two = in_final;
            phase_in  = PH_SECOND;
            left_in   = {2'b00, in_byte[1:0]};
         end
      endcase
      // a final byte closes the message
      if (in_final) begin
         phase_in = PH_FIRST;
         left_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         left_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   assign push_out.push  = take;
   assign push_out.entry = entry;

endmodule

// ----- design/b64_queue.sv -----
// ----------------------------------------------------------------------------
// b64_queue
// Short queue of classified entries between the front and back parts.
// ----------------------------------------------------------------------------
module b64_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  b64_pkg::b64_push_type push_in,
   output logic                  full,
   output b64_pkg::b64_head_type head,
   input  logic                  pop
);
   import b64_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push_in.push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_in.entry;
   end

endmodule

// ----- design/b64_back.sv -----
// ----------------------------------------------------------------------------
// b64_back
// Emits one base64 character per cycle from queued entries while out_ready is high.
// ----------------------------------------------------------------------------
module b64_back (
   input  logic                  clock,
   input  logic                  reset,
   input  b64_pkg::b64_head_type head,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [6:0]            out_char,
   output logic                  out_last
);
   import b64_pkg::*;

   logic                valid_ff;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                pend_ff, pend_in;
   logic [SEXTET_W-1:0] pend_sx_ff;
   logic                pend_last_ff;
   logic                load;
   logic                load_any;

   // output register free or its transfer completes now
   assign load     = !valid_ff || out_ready;
   assign pop      = load && !pend_ff && head.valid;
   assign load_any = load && (pend_ff || head.valid);

   always_comb begin
      pend_in = pend_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (load && pend_ff) begin
         char_in = sextet_to_ascii(pend_sx_ff);
         last_in = pend_last_ff;
         pend_in = 1'b0;
      end else if (pop) begin
         char_in = sextet_to_ascii(head.entry.sx0);
         last_in = head.entry.last && !head.entry.two;
         pend_in = head.entry.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         if (load)
            valid_ff <= load_any;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (pop) begin
         pend_sx_ff   <= head.entry.sx1;
         pend_last_ff <= head.entry.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

// ----- design/base64_unpadded_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_unpadded_encoder
// Byte stream to unpadded base64 character stream.
// ----------------------------------------------------------------------------
// One byte enters per transfer on req_ch, final_byte marking the message end;
// characters leave on rsp_ch one per cycle while it is ready, end_of_text on
// the last of them. A byte yields one character, or two (the third byte of a
// group, or a final byte); the single character output register is what
// sets the pace. Bytes are taken every cycle while the entry queue
// (QUEUE_DEPTH entries) has room; a byte is stored in the entry queue and
// then in the output register before its first character is offered.
// No '=' padding is produced.
// ----------------------------------------------------------------------------
module base64_unpadded_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic       clock,
   input logic       reset,
   b64_req_if.sink   req_ch,
   b64_rsp_if.source rsp_ch
);
   import b64_pkg::*;

   b64_push_type push;
   b64_head_type head;
   logic         queue_full;
   logic         pop;

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_byte    (req_ch.data_byte),
      .in_final   (req_ch.final_byte),
      .queue_full (queue_full),
      .push_out   (push)
   );

   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .head    (head),
      .pop     (pop)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_char  (rsp_ch.out_char),
      .out_last  (rsp_ch.end_of_text)
   );

endmodule

// ----- design/b64_checker.sv -----
// ----------------------------------------------------------------------------
// b64_checker
// Port level checks of the base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_char,
   input logic       rsp_eot
);

   // nothing left in flight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("character offered right after reset");

   // a stalled character stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_eot))
      else $error("stalled character changed");

   // only alphabet characters leave the block
   a_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char >= 7'h41 && rsp_char <= 7'h5A) ||
                    (rsp_char >= 7'h61 && rsp_char <= 7'h7A) ||
                    (rsp_char >= 7'h30 && rsp_char <= 7'h39) ||
                    rsp_char == 7'h2B || rsp_char == 7'h2F)
      else $error("character outside the base64 alphabet");

   // the queue is empty after reset, so a byte can be taken right after it
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready || reset)
      else $error("input not ready after reset");

   // an offered byte is refused only while output is backed up
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input refused with output idle");

endmodule

bind base64_unpadded_encoder b64_checker u_b64_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_char  (rsp_ch.out_char),
   .rsp_eot   (rsp_ch.end_of_text)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unpadded base64 encoder: byte messages go in
// with random gaps, each accepted byte is encoded by a local model into the
// characters it must produce, and every character out is compared in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_BYTES = 1850;
   localparam int HOLD_OFF_AT  = 500;
   localparam int HOLD_OFF_LEN = 200;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } raw_byte_t;

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } b64_char_t;

   typedef logic [7:0] byte_q_t[$];

   logic clock;
   logic reset;

   b64_req_if req_if ();
   b64_rsp_if rsp_if ();

   base64_unpadded_encoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   raw_byte_t pending_bytes[$];
   b64_char_t expected_chars[$];
   string     b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // encoder model state
   logic [1:0] enc_phase;
   logic [3:0] enc_left;

   int error_count;
   int cycle_count;
   int bytes_taken;
   int send_gap;
   int rsp_hold;
   int hold_off_left;
   logic hold_off_done;
   logic quiet;

   // periodic stretches with no idling on either side
   assign quiet = ((cycle_count / 3000) % 4) == 2;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap(input logic no_idle);
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic b64_char_t make_char(input logic [5:0] sx, input logic last);
      b64_char_t c;
      byte       a;
      a      = b64_alphabet[int'(sx)];
      c.code = a[6:0];
      c.last = last;
      return c;
   endfunction

   // model of one accepted byte: push the characters it produces
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      case (enc_phase)
         2'd1: begin
            expected_chars.push_back(make_char({enc_left[1:0], b[7:4]}, 1'b0));
            if (fin) begin
               expected_chars.push_back(make_char({b[3:0], 2'b00}, 1'b1));
            end else begin
               enc_left  = b[3:0];
               enc_phase = 2'd2;
            end
         end
         2'd2: begin
            expected_chars.push_back(make_char({enc_left, b[7:6]}, 1'b0));
            expected_chars.push_back(make_char(b[5:0], fin));
            enc_left  = 4'd0;
            enc_phase = 2'd0;
         end
         default: begin
            expected_chars.push_back(make_char(b[7:2], 1'b0));
            if (fin) begin
               expected_chars.push_back(make_char({b[1:0], 4'b0000}, 1'b1));
            end else begin
               enc_left  = {2'b00, b[1:0]};
               enc_phase = 2'd1;
            end
         end
      endcase
      if (fin) begin
         enc_phase = 2'd0;
         enc_left  = 4'd0;
      end
   endtask

   task automatic queue_message(input byte_q_t msg);
      raw_byte_t item;
      foreach (msg[i]) begin
         item.data = msg[i];
         item.fin  = (i == msg.size() - 1);
         pending_bytes.push_back(item);
      end
   endtask

   // driver: offers queued bytes, predicts on each transfer
   always @(posedge clock) begin
      raw_byte_t item;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
         bytes_taken  <= 0;
         enc_phase = 2'd0;
         enc_left  = 4'd0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            encode_byte(req_if.data_byte, req_if.final_byte);
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               req_if.valid <= 1'b0;
               send_gap     <= send_gap - 1;
            end else if (pending_bytes.size() > 0) begin
               item = pending_bytes.pop_front();
               req_if.valid      <= 1'b1;
               req_if.data_byte  <= item.data;
               req_if.final_byte <= item.fin;
               send_gap          <= pick_gap(quiet);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off so the encoder backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_off_left <= 0;
         hold_off_done <= 1'b0;
      end else if (!hold_off_done && bytes_taken >= HOLD_OFF_AT) begin
         hold_off_left <= HOLD_OFF_LEN;
         hold_off_done <= 1'b1;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   // monitor: checks each character transfer, drives ready
   always @(posedge clock) begin
      b64_char_t want;
      int        gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_chars.size() == 0) begin
               error_count++;
               $display("%0t: unexpected char, expected none, actual %h last %b",
                        $time, rsp_if.out_char, rsp_if.end_of_text);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_if.out_char !== want.code) begin
                  error_count++;
                  $display("%0t: out_char mismatch, expected %h, actual %h",
                           $time, want.code, rsp_if.out_char);
               end
               if (rsp_if.end_of_text !== want.last) begin
                  error_count++;
                  $display("%0t: end_of_text mismatch, expected %b, actual %b",
                           $time, want.last, rsp_if.end_of_text);
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= rsp_hold - 1;
         end else if (hold_off_left > 0) begin
            rsp_if.ready <= 1'b0;
         end else if (rsp_if.valid && rsp_if.ready) begin
            gap = pick_gap(quiet);
            rsp_if.ready <= (gap == 0);
            rsp_hold     <= (gap > 0) ? gap - 1 : 0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      byte_q_t msg;
      int      total;
      int      len;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_byte   = 8'h00;
      req_if.final_byte  = 1'b0;
      rsp_if.ready       = 1'b0;
      error_count        = 0;
      cycle_count        = 0;

      // single bytes at both extremes, then messages ending in every phase
      queue_message('{8'h00});
      queue_message('{8'hFF});
      queue_message('{8'hFB, 8'hFF});
      queue_message('{8'hFB, 8'hEF, 8'hBF});
      queue_message('{8'hFF, 8'hFF, 8'hFF, 8'h00});
      queue_message('{8'h00, 8'h10, 8'h83, 8'h10, 8'h51});
      queue_message('{8'h4D, 8'h61, 8'h6E});
      queue_message('{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA});

      total = 0;
      while (total < RANDOM_BYTES) begin
         msg.delete();
         if ($urandom_range(0, 15) == 0)
            len = $urandom_range(10, 60);
         else
            len = $urandom_range(1, 9);
         repeat (len) msg.push_back(8'($urandom_range(0, 255)));
         queue_message(msg);
         total += len;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_if.valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_chars.size() != 0) begin
         error_count++;
         $display("%0t: %0d chars still expected at end", $time, expected_chars.size());
      end

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
